### rtl/dsf_pkg.sv
// ----------------------------------------------------------------------------
// dsf_pkg
// Register indexes, spring kind codes and output limits for the damped
// spring force pipeline.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int REG_INDEX_WIDTH = 3;
  typedef logic [REG_INDEX_WIDTH-1:0] reg_index_t;

  localparam reg_index_t REG_STIFF_STRUCTURAL = 3'd0;
  localparam reg_index_t REG_DAMP_STRUCTURAL  = 3'd1;
  localparam reg_index_t REG_STIFF_SHEAR      = 3'd2;
  localparam reg_index_t REG_DAMP_SHEAR       = 3'd3;
  localparam reg_index_t REG_STIFF_BEND       = 3'd4;
  localparam reg_index_t REG_DAMP_BEND        = 3'd5;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_STRUCTURAL = 2'd0;
  localparam kind_t KIND_SHEAR      = 2'd1;
  localparam kind_t KIND_BEND       = 2'd2;

  localparam int OUT_WIDTH = 32;

  typedef logic [OUT_WIDTH-1:0] force_t;

  localparam force_t OUT_MAX = 32'h7fff_ffff;
  localparam force_t OUT_MIN = 32'h8000_0000;

  // magnitude limits, one bit wider than the output
  localparam logic [OUT_WIDTH:0] OUT_POS_LIMIT = 33'h0_7fff_ffff;
  localparam logic [OUT_WIDTH:0] OUT_NEG_LIMIT = 33'h0_8000_0000;

endpackage

### rtl/damped_spring_force_top.sv
// ----------------------------------------------------------------------------
// damped_spring_force_top
// Damped spring force of one cloth spring: length by a bit-per-stage square
// root, projection and force scaling by bit-per-stage dividers.
//
//   channel | signals                                   | accepted when
//   --------+-------------------------------------------+---------------------
//   in      | in_valid, in_stall, delta_*, rest_length, | in_valid & !in_stall
//           | spring_kind                               |
//   out     | out_valid, out_stall, force_*, zero_length| out_valid & !out_stall
//   cfg     | cfg_write_en, cfg_index, cfg_data         | cfg_write_en
//
// One item per cycle while the pipeline is not held; 3*COORD_WIDTH+13 register
// stages from the input register to out_valid. Depth is set by the square
// root (COORD_WIDTH stages), the projection divider (COORD_WIDTH+1 stages) and
// the force divider (COORD_WIDTH+4 stages, three lanes).
// The whole pipeline holds while a result waits under out_stall; in_stall
// follows it. Reset clears valid bits and loads default coefficients.
// ----------------------------------------------------------------------------
module damped_spring_force_top
  import dsf_pkg::*;
#(
  parameter int COORD_WIDTH    = 24,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_WIDTH-1:0]    delta_x,
  input  logic signed [COORD_WIDTH-1:0]    delta_y,
  input  logic signed [COORD_WIDTH-1:0]    delta_z,
  input  logic signed [COORD_WIDTH-1:0]    delta_vx,
  input  logic signed [COORD_WIDTH-1:0]    delta_vy,
  input  logic signed [COORD_WIDTH-1:0]    delta_vz,
  input  logic        [COORD_WIDTH-2:0]    rest_length,
  input  logic        [1:0]                spring_kind,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [OUT_WIDTH-1:0]      force_x,
  output logic signed [OUT_WIDTH-1:0]      force_y,
  output logic signed [OUT_WIDTH-1:0]      force_z,
  output logic                             zero_length,
  input  logic                             cfg_write_en,
  input  logic        [REG_INDEX_WIDTH-1:0] cfg_index,
  input  logic        [COEF_FRAC_BITS+1:0] cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int F   = COEF_FRAC_BITS;
  localparam int CW  = F + 2;
  localparam int QP  = W + 1;          // projection quotient bits
  localparam int QF  = W + 4;          // force quotient bits
  localparam int TW  = W + 4;          // signed total force term
  localparam int SQW = 2 * W + 1;      // square root remainder
  localparam int DPW = 2 * W;          // projection dividend
  localparam int DFW = 2 * W + 3;      // force dividend
  localparam int SW  = (QF > OUT_WIDTH + 1) ? QF : OUT_WIDTH + 1;

  localparam logic [CW-1:0] RST_HALF = CW'(64'd1 << (F - 1));
  localparam logic [CW-1:0] RST_QNEG = CW'(64'd0 - (64'd1 << (F - 2)));
  localparam logic [CW-1:0] RST_BEND = CW'(((64'd85 << F) + 64'd50) / 64'd100);

  typedef struct packed {
    logic [2:0][W-1:0] md;
    logic [2:0]        sd;
    logic [CW-1:0]     ks;
    logic [CW-1:0]     kd;
    logic [W-2:0]      rest;
    logic              zero;
  } geo_t;

  function automatic force_t sat_force(input logic neg, input logic [QF-1:0] m);
    logic [SW-1:0] me;
    logic [SW-1:0] nm;
    force_t        res;
    me = SW'(m);
    nm = -me;
    if (!neg) begin
      res = (me > SW'(OUT_POS_LIMIT)) ? OUT_MAX : me[OUT_WIDTH-1:0];
    end else begin
      res = (me > SW'(OUT_NEG_LIMIT)) ? OUT_MIN : nm[OUT_WIDTH-1:0];
    end
    return res;
  endfunction

  // pipeline advance
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // --------------------------------------------------------------------------
  // coefficient registers
  logic [CW-1:0] ks_reg [3];
  logic [CW-1:0] kd_reg [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ks_reg[0] <= RST_HALF;
      kd_reg[0] <= RST_QNEG;
      ks_reg[1] <= RST_HALF;
      kd_reg[1] <= RST_QNEG;
      ks_reg[2] <= RST_BEND;
      kd_reg[2] <= RST_QNEG;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_STIFF_STRUCTURAL: ks_reg[0] <= cfg_data;
        REG_DAMP_STRUCTURAL:  kd_reg[0] <= cfg_data;
        REG_STIFF_SHEAR:      ks_reg[1] <= cfg_data;
        REG_DAMP_SHEAR:       kd_reg[1] <= cfg_data;
        REG_STIFF_BEND:       ks_reg[2] <= cfg_data;
        REG_DAMP_BEND:        kd_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: input register
  logic              v1;
  logic [2:0][W-1:0] d1;
  logic [2:0][W-1:0] dv1;
  logic [W-2:0]      rest1;
  kind_t             kind1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1    <= {delta_z, delta_y, delta_x};
      dv1   <= {delta_vz, delta_vy, delta_vx};
      rest1 <= rest_length;
      kind1 <= spring_kind;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: magnitudes, squares, dot products, coefficient select
  logic [2:0][W-1:0] md1;
  logic [2:0][W-1:0] mv1;
  logic [1:0]        sel1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      md1[i] = d1[i][W-1]  ? W'(-d1[i])  : d1[i];
      mv1[i] = dv1[i][W-1] ? W'(-dv1[i]) : dv1[i];
    end
    case (kind1)
      KIND_STRUCTURAL: sel1 = 2'd0;
      KIND_SHEAR:      sel1 = 2'd1;
      default:         sel1 = 2'd2;   // bend, and the unused code
    endcase
  end

  logic                v2;
  logic [2:0][W-1:0]   md2;
  logic [2:0]          sd2;
  logic [2:0]          dn2;
  logic [2:0][2*W-1:0] sq2;
  logic [2:0][2*W-1:0] dp2;
  logic [CW-1:0]       ks2;
  logic [CW-1:0]       kd2;
  logic [W-2:0]        rest2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        md2[i] <= md1[i];
        sd2[i] <= d1[i][W-1];
        dn2[i] <= d1[i][W-1] ^ dv1[i][W-1];
        sq2[i] <= (2*W)'(md1[i]) * (2*W)'(md1[i]);
        dp2[i] <= (2*W)'(md1[i]) * (2*W)'(mv1[i]);
      end
      ks2   <= ks_reg[sel1];
      kd2   <= kd_reg[sel1];
      rest2 <= rest1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: sums; feeds the square root as its stage 0
  logic [2*W-1:0] sumsq2;
  logic [2*W-1:0] pos2;
  logic [2*W-1:0] neg2;

  always_comb begin
    sumsq2 = sq2[0] + sq2[1] + sq2[2];
    pos2   = '0;
    neg2   = '0;
    for (int i = 0; i < 3; i++) begin
      if (dn2[i]) begin
        neg2 = neg2 + dp2[i];
      end else begin
        pos2 = pos2 + dp2[i];
      end
    end
  end

  logic           sq_v  [0:W];
  logic [SQW-1:0] sq_r  [0:W];
  logic [W-1:0]   sq_q  [0:W];
  logic [DPW-1:0] sq_dm [0:W];
  logic           sq_pn [0:W];
  geo_t           sq_g  [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0]      <= SQW'(sumsq2);
      sq_q[0]      <= '0;
      sq_dm[0]     <= (pos2 >= neg2) ? pos2 - neg2 : neg2 - pos2;
      sq_pn[0]     <= neg2 > pos2;
      sq_g[0].md   <= md2;
      sq_g[0].sd   <= sd2;
      sq_g[0].ks   <= ks2;
      sq_g[0].kd   <= kd2;
      sq_g[0].rest <= rest2;
      sq_g[0].zero <= (md2 == '0);
    end
  end

  // square root, one root bit per stage
  for (genvar k = 1; k <= W; k++) begin : g_sqrt
    localparam int B = W - k;
    logic [SQW-1:0] term;
    assign term = (SQW'(sq_q[k-1]) << (B + 1)) | (SQW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k] <= 1'b0;
      end else if (en) begin
        sq_v[k] <= sq_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_r[k-1] >= term) begin
          sq_r[k] <= sq_r[k-1] - term;
          sq_q[k] <= sq_q[k-1] | (W'(1) << B);
        end else begin
          sq_r[k] <= sq_r[k-1];
          sq_q[k] <= sq_q[k-1];
        end
        sq_dm[k] <= sq_dm[k-1];
        sq_pn[k] <= sq_pn[k-1];
        sq_g[k]  <= sq_g[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // projection divider: |dot| / len, one quotient bit per stage
  logic           pd_v   [0:QP];
  logic [DPW-1:0] pd_r   [0:QP];
  logic [QP-1:0]  pd_q   [0:QP];
  logic [W-1:0]   pd_len [0:QP];
  logic           pd_pn  [0:QP];
  geo_t           pd_g   [0:QP];

  always_ff @(posedge clk) begin
    if (rst) begin
      pd_v[0] <= 1'b0;
    end else if (en) begin
      pd_v[0] <= sq_v[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0]   <= sq_dm[W];
      pd_q[0]   <= '0;
      pd_len[0] <= sq_q[W];
      pd_pn[0]  <= sq_pn[W];
      pd_g[0]   <= sq_g[W];
    end
  end

  for (genvar k = 1; k <= QP; k++) begin : g_proj
    localparam int B = QP - k;
    logic [DPW-1:0] trial;
    assign trial = DPW'(pd_len[k-1]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        pd_v[k] <= 1'b0;
      end else if (en) begin
        pd_v[k] <= pd_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (pd_r[k-1] >= trial) begin
          pd_r[k] <= pd_r[k-1] - trial;
          pd_q[k] <= pd_q[k-1] | (QP'(1) << B);
        end else begin
          pd_r[k] <= pd_r[k-1];
          pd_q[k] <= pd_q[k-1];
        end
        pd_len[k] <= pd_len[k-1];
        pd_pn[k]  <= pd_pn[k-1];
        pd_g[k]   <= pd_g[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // c1: coefficient products
  geo_t                pe;
  logic signed [W:0]   stretch;
  logic [W-1:0]        st_mag;
  logic [CW-1:0]       ks_mag;
  logic [CW-1:0]       kd_mag;

  always_comb begin
    pe      = pd_g[QP];
    stretch = $signed({1'b0, pd_len[QP]}) - $signed({2'b00, pe.rest});
    st_mag  = stretch[W] ? W'(-stretch) : W'(stretch);
    ks_mag  = pe.ks[CW-1] ? CW'(-pe.ks) : pe.ks;
    kd_mag  = pe.kd[CW-1] ? CW'(-pe.kd) : pe.kd;
  end

  logic                v_c1;
  logic [CW+W-1:0]     fs_c1;
  logic                fsn_c1;
  logic [CW+QP-1:0]    fd_c1;
  logic                fdn_c1;
  logic [2:0][W-1:0]   md_c1;
  logic [2:0]          sd_c1;
  logic [W-1:0]        len_c1;
  logic                zero_c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c1 <= 1'b0;
    end else if (en) begin
      v_c1 <= pd_v[QP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fs_c1   <= (CW+W)'(ks_mag) * (CW+W)'(st_mag);
      fsn_c1  <= pe.ks[CW-1] ^ stretch[W];
      fd_c1   <= (CW+QP)'(kd_mag) * (CW+QP)'(pd_q[QP]);
      fdn_c1  <= pe.kd[CW-1] ^ pd_pn[QP];
      md_c1   <= pe.md;
      sd_c1   <= pe.sd;
      len_c1  <= pd_len[QP];
      zero_c1 <= pe.zero;
    end
  end

  // --------------------------------------------------------------------------
  // c2: scale and combine, total = fD - kS*stretch
  logic [W+1:0]         fs_sc;
  logic [W+2:0]         fd_sc;
  logic signed [TW-1:0] fs_s;
  logic signed [TW-1:0] fd_s;

  always_comb begin
    fs_sc = fs_c1[CW+W-1:F];
    fd_sc = fd_c1[CW+QP-1:F];
    fs_s  = fsn_c1 ? -$signed(TW'(fs_sc)) : $signed(TW'(fs_sc));
    fd_s  = fdn_c1 ? -$signed(TW'(fd_sc)) : $signed(TW'(fd_sc));
  end

  logic                 v_c2;
  logic signed [TW-1:0] tot_c2;
  logic [2:0][W-1:0]    md_c2;
  logic [2:0]           sd_c2;
  logic [W-1:0]         len_c2;
  logic                 zero_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_c2 <= 1'b0;
    end else if (en) begin
      v_c2 <= v_c1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tot_c2  <= fd_s - fs_s;
      md_c2   <= md_c1;
      sd_c2   <= sd_c1;
      len_c2  <= len_c1;
      zero_c2 <= zero_c1;
    end
  end

  // --------------------------------------------------------------------------
  // c3: |total| * |d_i|; feeds the force divider as its stage 0
  logic [TW-2:0] tmag;
  assign tmag = tot_c2[TW-1] ? (TW-1)'(-tot_c2) : (TW-1)'(tot_c2);

  logic                fr_v    [0:QF];
  logic [2:0][DFW-1:0] fr_r    [0:QF];
  logic [2:0][QF-1:0]  fr_q    [0:QF];
  logic [2:0]          fr_sn   [0:QF];
  logic [W-1:0]        fr_len  [0:QF];
  logic                fr_zero [0:QF];

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_v[0] <= 1'b0;
    end else if (en) begin
      fr_v[0] <= v_c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fr_r[0][i]  <= DFW'(tmag) * DFW'(md_c2[i]);
        fr_sn[0][i] <= tot_c2[TW-1] ^ sd_c2[i];
      end
      fr_q[0]    <= '0;
      fr_len[0]  <= len_c2;
      fr_zero[0] <= zero_c2;
    end
  end

  for (genvar k = 1; k <= QF; k++) begin : g_force
    localparam int B = QF - k;
    logic [DFW-1:0] trial;
    assign trial = DFW'(fr_len[k-1]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        fr_v[k] <= 1'b0;
      end else if (en) begin
        fr_v[k] <= fr_v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (fr_r[k-1][i] >= trial) begin
            fr_r[k][i] <= fr_r[k-1][i] - trial;
            fr_q[k][i] <= fr_q[k-1][i] | (QF'(1) << B);
          end else begin
            fr_r[k][i] <= fr_r[k-1][i];
            fr_q[k][i] <= fr_q[k-1][i];
          end
        end
        fr_sn[k]   <= fr_sn[k-1];
        fr_len[k]  <= fr_len[k-1];
        fr_zero[k] <= fr_zero[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register with saturation; coincident ends give zero force
  force_t [2:0] sat_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_out[i] = sat_force(fr_sn[QF][i] && (fr_q[QF][i] != '0), fr_q[QF][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fr_v[QF];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x     <= fr_zero[QF] ? '0 : sat_out[0];
      force_y     <= fr_zero[QF] ? '0 : sat_out[1];
      force_z     <= fr_zero[QF] ? '0 : sat_out[2];
      zero_length <= fr_zero[QF];
    end
  end

endmodule
